// File: sv/rope_pkg.sv
// shared types, constants and tables for the rotary position embedding unit
package rope_pkg;

	localparam int MAX_PAIRS    = 64;
	localparam int CORDIC_STEPS = 16;
	localparam int IDX_W        = $clog2(MAX_PAIRS);
	localparam int CS_W         = 34;
	// read, two blend stages, frequency, angle, fold, steps, quadrant, three math, output
	localparam int LAT          = CORDIC_STEPS + 11;
	localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

	typedef enum logic [2:0] {
		CFG_YARN_ENABLE  = 3'd0,
		CFG_INV_FACTOR   = 3'd1,
		CFG_RAMP_LOW     = 3'd2,
		CFG_RAMP_INV_W   = 3'd3,
		CFG_MAG_SCALE    = 3'd4,
		CFG_MAX_POS      = 3'd5,
		CFG_HALF_DIM     = 3'd6
	} cfg_index_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_ROTATE = 1'b1;

	// per-item data carried alongside the arithmetic
	typedef struct packed {
		logic              rot;
		logic [IDX_W-1:0]  idx;
		logic signed [15:0] even;
		logic signed [15:0] odd;
	} meta_t;

	// arctangent of 2^-i in turns, Q0.32
	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
			15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
			21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
			24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
			27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: sv/rope_cordic.sv
// pipelined quadrant-folded cordic giving cosine and sine of an angle in turns
module rope_cordic
	import rope_pkg::*;
(
	input  logic                   clk,
	input  logic                   adv,
	input  logic [31:0]            angle,
	output logic signed [CS_W-1:0] cos_out,
	output logic signed [CS_W-1:0] sin_out
);

	logic signed [CS_W-1:0] x_q [0:CORDIC_STEPS];
	logic signed [CS_W-1:0] y_q [0:CORDIC_STEPS];
	logic signed [CS_W-1:0] z_q [0:CORDIC_STEPS];
	logic [1:0]             q_q [0:CORDIC_STEPS];
	logic [31:0]            rounded;
	logic [1:0]             quad;
	logic [31:0]            resid;

	// quadrant just above the angle and residual to it, in [-1/4, 0) turn
	assign rounded = angle + 32'h40000000;
	assign quad    = rounded[31:30];
	assign resid   = angle - {quad, 30'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q[0] <= CS_W'(CORDIC_GAIN);
			y_q[0] <= '0;
			z_q[0] <= CS_W'($signed(resid));
			q_q[0] <= quad;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CS_W-1:0] dx, dy, at;
		assign dx = x_q[i] >>> i;
		assign dy = y_q[i] >>> i;
		assign at = CS_W'(atan_turns(i));
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_q[i][CS_W-1]) begin
					x_q[i+1] <= x_q[i] - dy;
					y_q[i+1] <= y_q[i] + dx;
					z_q[i+1] <= z_q[i] - at;
				end else begin
					x_q[i+1] <= x_q[i] + dy;
					y_q[i+1] <= y_q[i] - dx;
					z_q[i+1] <= z_q[i] + at;
				end
				q_q[i+1] <= q_q[i];
			end
		end
	end

	// apply the quadrant exactly
	always_ff @(posedge clk) begin
		if (adv) begin
			case (q_q[CORDIC_STEPS])
				2'd0: begin
					cos_out <= x_q[CORDIC_STEPS];
					sin_out <= y_q[CORDIC_STEPS];
				end
				2'd1: begin
					cos_out <= -y_q[CORDIC_STEPS];
					sin_out <= x_q[CORDIC_STEPS];
				end
				2'd2: begin
					cos_out <= -x_q[CORDIC_STEPS];
					sin_out <= -y_q[CORDIC_STEPS];
				end
				default: begin
					cos_out <= y_q[CORDIC_STEPS];
					sin_out <= -x_q[CORDIC_STEPS];
				end
			endcase
		end
	end

endmodule

// File: sv/rotary_position_embedding_unit.sv
// rotary position embedding with yarn frequency blending, top level
// throughput: one transaction per cycle unless the output is held,
// set by the fully unrolled cordic and math pipeline
// load transactions give no result; the whole pipeline stalls as one
// reset: async active low, clears valid bits, sets configuration to defaults; frequency table is not cleared
module rotary_position_embedding_unit
	import rope_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [5:0]          pair_index,
	input  logic [31:0]         frequency_turns,
	input  logic [15:0]         position,
	input  logic signed [15:0]  even_value,
	input  logic signed [15:0]  odd_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [5:0]          pair_index_res,
	output logic signed [15:0]  first_value,
	output logic signed [15:0]  second_value,
	output logic                rotated
);

	// configuration registers
	logic        yarn_q;
	logic [16:0] inv_factor_q;
	logic [6:0]  ramp_low_q;
	logic [23:0] ramp_inv_w_q;
	logic [15:0] mag_q;
	logic [16:0] max_pos_q;
	logic [6:0]  half_dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yarn_q       <= 1'b0;
			inv_factor_q <= 17'd65536;
			ramp_low_q   <= 7'd0;
			ramp_inv_w_q <= 24'd65536;
			mag_q        <= 16'd16384;
			max_pos_q    <= 17'd4096;
			half_dim_q   <= 7'd32;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_YARN_ENABLE: yarn_q       <= cfg_data[0];
				CFG_INV_FACTOR:  inv_factor_q <= cfg_data[16:0];
				CFG_RAMP_LOW:    ramp_low_q   <= cfg_data[6:0];
				CFG_RAMP_INV_W:  ramp_inv_w_q <= cfg_data;
				CFG_MAG_SCALE:   mag_q        <= cfg_data[15:0];
				CFG_MAX_POS:     max_pos_q    <= cfg_data[16:0];
				CFG_HALF_DIM:    half_dim_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: everything moves unless the output is held
	logic adv, accept;
	logic valid_q [1:LAT];
	meta_t meta_q [1:LAT];

	assign adv      = !valid_q[LAT] || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) valid_q[k] <= 1'b0;
		end else if (adv) begin
			valid_q[1] <= accept && (operation == OP_ROTATE);
			for (int k = 2; k <= LAT; k++) valid_q[k] <= valid_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q[1].rot  <= (17'(position) < max_pos_q) && (7'(pair_index) < half_dim_q);
			meta_q[1].idx  <= pair_index;
			meta_q[1].even <= even_value;
			meta_q[1].odd  <= odd_value;
			for (int k = 2; k <= LAT; k++) meta_q[k] <= meta_q[k-1];
		end
	end

	// frequency table: write on load, read on every advance
	logic [31:0] freq_mem [0:MAX_PAIRS-1];
	logic [31:0] f_s1;

	always_ff @(posedge clk) begin
		if (accept && (operation == OP_LOAD)) freq_mem[pair_index] <= frequency_turns;
		if (adv) f_s1 <= freq_mem[pair_index];
	end

	// ramp over the pair index
	logic [6:0]  ramp_d;
	logic [29:0] ramp_prod;
	logic [16:0] ramp_s1, ramp_s2;
	logic [15:0] pos_s1, pos_s2, pos_s3, pos_s4;

	assign ramp_d    = 7'(pair_index) - ramp_low_q;
	assign ramp_prod = 30'(ramp_d[5:0]) * 30'(ramp_inv_w_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (7'(pair_index) <= ramp_low_q)   ramp_s1 <= 17'd0;
			else if (ramp_prod > 30'd65536)     ramp_s1 <= 17'd65536;
			else                                ramp_s1 <= ramp_prod[16:0];
			pos_s1 <= position;
		end
	end

	// blend with the scaled frequency
	logic [48:0] fi_full;
	logic [32:0] fi_s2;
	logic [31:0] f_s2, f_s3;
	logic [49:0] p1_s3;
	logic [48:0] p2_s3;
	logic [50:0] blend_sum;
	logic [31:0] freq_s4, angle_s5;
	logic [47:0] angle_full;

	assign fi_full   = 49'(f_s1) * 49'(inv_factor_q);
	assign blend_sum = 51'(p1_s3) + 51'(p2_s3) + 51'd32768;
	assign angle_full = 48'(freq_s4) * 48'(pos_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			fi_s2   <= fi_full[48:16];
			f_s2    <= f_s1;
			ramp_s2 <= ramp_s1;
			pos_s2  <= pos_s1;
			p1_s3   <= 50'(fi_s2) * 50'(ramp_s2);
			p2_s3   <= 49'(f_s2) * 49'(17'd65536 - ramp_s2);
			f_s3    <= f_s2;
			pos_s3  <= pos_s2;
			freq_s4 <= yarn_q ? blend_sum[47:16] : f_s3;
			pos_s4  <= pos_s3;
			angle_s5 <= angle_full[31:0];
		end
	end

	// cosine and sine
	logic signed [CS_W-1:0] c_cs, s_cs;

	rope_cordic u_cordic (
		.clk     (clk),
		.adv     (adv),
		.angle   (angle_s5),
		.cos_out (c_cs),
		.sin_out (s_cs)
	);

	// rotate, scale, round and saturate
	localparam int M1 = CORDIC_STEPS + 8;
	logic signed [49:0] ec_sa, os_sa, oc_sa, es_sa;
	logic signed [50:0] a1_sb, a2_sb;
	logic signed [67:0] r1_sc, r2_sc;
	logic signed [16:0] mag_sg;

	assign mag_sg = $signed({1'b0, mag_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			ec_sa <= 50'(meta_q[M1-1].even) * 50'(c_cs);
			os_sa <= 50'(meta_q[M1-1].odd) * 50'(s_cs);
			oc_sa <= 50'(meta_q[M1-1].odd) * 50'(c_cs);
			es_sa <= 50'(meta_q[M1-1].even) * 50'(s_cs);
			a1_sb <= 51'(ec_sa) - 51'(os_sa);
			a2_sb <= 51'(oc_sa) + 51'(es_sa);
			r1_sc <= 68'(a1_sb) * 68'(mag_sg);
			r2_sc <= 68'(a2_sb) * 68'(mag_sg);
		end
	end

	function automatic logic signed [15:0] round_sat(input logic signed [67:0] acc);
		logic signed [67:0] t;
		logic signed [23:0] r;
		t = acc + 68'sh800_0000_0000;
		r = 24'(t >>> 44);
		if (r > 24'sd32767)       return 16'sh7FFF;
		else if (r < -24'sd32768) return 16'sh8000;
		else                      return r[15:0];
	endfunction

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			pair_index_res <= meta_q[LAT-1].idx;
			rotated        <= meta_q[LAT-1].rot;
			first_value    <= meta_q[LAT-1].rot ? round_sat(r1_sc) : meta_q[LAT-1].even;
			second_value   <= meta_q[LAT-1].rot ? round_sat(r2_sc) : meta_q[LAT-1].odd;
		end
	end

	assign out_valid = valid_q[LAT];

endmodule

// File: sv/rope_checker.sv
// port-level checks for the rotary position embedding unit
module rope_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] first_value,
	input logic        rotated
);

	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input blocked with empty output");

	// a held result stalls the whole pipeline
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");

	// a result waiting for ready holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_value) && $stable(rotated))
		else $error("result changed while stalled");

endmodule

bind rotary_position_embedding_unit rope_checker u_rope_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.first_value (first_value),
	.rotated     (rotated)
);
